FILE: src/gc_pkg.sv
package gc_pkg;

   localparam int CHANNEL_COUNT_DEF = 4;
   localparam int SAMPLE_BITS_DEF   = 16;

   // channel slots in a beat, fixed by the pixel format
   localparam int NUM_SLOTS  = 4;
   localparam int GAMMA_BITS = 16;
   localparam int CSR_IDX_W  = 2;

   // log/exp precision
   localparam int EBITS     = 28;
   localparam int QBITS     = 30;
   localparam int GAMMA_FRAC = 13;
   localparam int SHIFT_W   = 6;
   localparam int ZERO_SHIFT = 40;

   function automatic int mag_w(input int sb);
      return EBITS + $clog2(sb - 3);
   endfunction

   function automatic int dv_w(input int sb);
      return mag_w(sb) + GAMMA_FRAC;
   endfunction

   // entry + squaring + magnitude + divider + split + roots + round
   function automatic int depth(input int sb);
      return 4 + 2 * EBITS + dv_w(sb);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] t;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      t = v;
      for (int i = 0; i < 32; i++) begin
         if (t >= r + b) begin
            t = t - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-(k+1)) in Q30, by the same truncated square-root chain
   function automatic logic [30:0] root_q30(input int k);
      logic [63:0] r;
      r = isqrt64(64'd2 << (2 * QBITS));
      for (int j = 1; j < EBITS; j++) begin
         if (j <= k) begin
            r = isqrt64(r << QBITS);
         end
      end
      return r[30:0];
   endfunction

endpackage

FILE: src/gc_chan.sv
module gc_chan #(
   parameter int SB = gc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            adv,
   input  logic                            apply,
   input  logic [gc_pkg::GAMMA_BITS-1:0]   gamma,
   input  logic [SB-1:0]                   x_in,
   output logic [SB-1:0]                   y_out
);

   localparam int FRAC  = SB - 4;
   localparam int PW    = $clog2(SB);
   localparam int EB    = gc_pkg::EBITS;
   localparam int MAGW  = gc_pkg::mag_w(SB);
   localparam int DVW   = gc_pkg::dv_w(SB);
   localparam int IQW   = DVW - EB;
   localparam int SW    = gc_pkg::SHIFT_W;
   localparam int GW    = gc_pkg::GAMMA_BITS;
   localparam logic [SB-1:0] ONE  = SB'(1) << FRAC;
   localparam logic [SB-1:0] SMAX = '1;

   // ---------------- entry: specials, leading one, normalize
   logic [PW-1:0] lead;
   logic          fix0;
   logic [SB-1:0] fixv0;

   always_comb begin
      lead = '0;
      for (int i = 0; i < SB; i++) begin
         if (x_in[i]) lead = PW'(i);
      end
      fix0  = 1'b1;
      fixv0 = x_in;
      if (!apply) begin
         fixv0 = x_in;
      end else if (gamma == '0) begin
         if (x_in < ONE)       fixv0 = '0;
         else if (x_in == ONE) fixv0 = ONE;
         else                  fixv0 = SMAX;
      end else if (x_in == '0) begin
         fixv0 = '0;
      end else begin
         fix0 = 1'b0;
      end
   end

   logic [30:0]    sq_m_ff  [EB+1];
   logic [EB-1:0]  sq_fr_ff [EB+1];
   logic [PW-1:0]  sq_p_ff  [EB+1];
   logic           sq_fx_ff [EB+1];
   logic [SB-1:0]  sq_fv_ff [EB+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_m_ff[0]  <= 31'(x_in) << (SW'(gc_pkg::QBITS) - SW'(lead));
         sq_fr_ff[0] <= '0;
         sq_p_ff[0]  <= lead;
         sq_fx_ff[0] <= fix0;
         sq_fv_ff[0] <= fixv0;
      end
   end

   // ---------------- log2 fraction, one squaring per stage
   for (genvar k = 0; k < EB; k++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      always_comb begin
         sq = 62'(sq_m_ff[k]) * 62'(sq_m_ff[k]);
         t  = sq[61:30];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_m_ff[k+1]  <= t[31] ? t[31:1] : t[30:0];
            sq_fr_ff[k+1] <= {sq_fr_ff[k][EB-2:0], t[31]};
            sq_p_ff[k+1]  <= sq_p_ff[k];
            sq_fx_ff[k+1] <= sq_fx_ff[k];
            sq_fv_ff[k+1] <= sq_fv_ff[k];
         end
      end
   end

   // ---------------- |log2(x)| and sign
   logic            mg_neg;
   logic [PW-1:0]   mg_ip;
   logic [MAGW-1:0] mg_val;

   always_comb begin
      mg_neg = sq_p_ff[EB] < PW'(FRAC);
      mg_ip  = mg_neg ? PW'(FRAC) - sq_p_ff[EB] : sq_p_ff[EB] - PW'(FRAC);
      if (mg_neg) mg_val = (MAGW'(mg_ip) << EB) - MAGW'(sq_fr_ff[EB]);
      else        mg_val = (MAGW'(mg_ip) << EB) | MAGW'(sq_fr_ff[EB]);
   end

   logic [GW-1:0]  dv_rem_ff [DVW+1];
   logic [DVW-1:0] dv_dq_ff  [DVW+1];
   logic           dv_neg_ff [DVW+1];
   logic           dv_fx_ff  [DVW+1];
   logic [SB-1:0]  dv_fv_ff  [DVW+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0] <= '0;
         dv_dq_ff[0]  <= DVW'(mg_val) << gc_pkg::GAMMA_FRAC;
         dv_neg_ff[0] <= mg_neg;
         dv_fx_ff[0]  <= sq_fx_ff[EB];
         dv_fv_ff[0]  <= sq_fv_ff[EB];
      end
   end

   // ---------------- restoring divide by gamma, one quotient bit per stage
   for (genvar j = 0; j < DVW; j++) begin : g_dv
      logic [GW:0] t;
      logic        ge;
      always_comb begin
         t  = {dv_rem_ff[j], dv_dq_ff[j][DVW-1]};
         ge = t >= {1'b0, gamma};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j+1] <= ge ? GW'(t - {1'b0, gamma}) : t[GW-1:0];
            dv_dq_ff[j+1]  <= {dv_dq_ff[j][DVW-2:0], ge};
            dv_neg_ff[j+1] <= dv_neg_ff[j];
            dv_fx_ff[j+1]  <= dv_fx_ff[j];
            dv_fv_ff[j+1]  <= dv_fv_ff[j];
         end
      end
   end

   // ---------------- split exponent into shift and fraction
   logic [IQW-1:0] sp_ip;
   logic [EB-1:0]  sp_fp;
   logic [IQW:0]   sp_sneg;
   logic           sp_fix;
   logic [SB-1:0]  sp_fixv;
   logic [EB-1:0]  sp_f;
   logic [SW-1:0]  sp_s;

   always_comb begin
      sp_ip   = dv_dq_ff[DVW][DVW-1:EB];
      sp_fp   = dv_dq_ff[DVW][EB-1:0];
      sp_sneg = (IQW+1)'(gc_pkg::QBITS - FRAC) + (IQW+1)'(sp_ip)
              + (IQW+1)'(sp_fp != '0);
      sp_fix  = dv_fx_ff[DVW];
      sp_fixv = dv_fv_ff[DVW];
      if (dv_neg_ff[DVW]) begin
         sp_f = EB'(0) - sp_fp;
         sp_s = SW'(sp_sneg);
         if (!dv_fx_ff[DVW] && sp_sneg > (IQW+1)'(gc_pkg::ZERO_SHIFT)) begin
            sp_fix  = 1'b1;
            sp_fixv = '0;
         end
      end else begin
         sp_f = sp_fp;
         sp_s = SW'(gc_pkg::QBITS - FRAC) - SW'(sp_ip[1:0]);
         if (!dv_fx_ff[DVW] && sp_ip >= IQW'(4)) begin
            sp_fix  = 1'b1;
            sp_fixv = SMAX;
         end
      end
   end

   logic [30:0]   pw_p_ff  [EB+1];
   logic [EB-1:0] pw_f_ff  [EB+1];
   logic [SW-1:0] pw_s_ff  [EB+1];
   logic          pw_fx_ff [EB+1];
   logic [SB-1:0] pw_fv_ff [EB+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         pw_p_ff[0]  <= 31'd1 << gc_pkg::QBITS;
         pw_f_ff[0]  <= sp_f;
         pw_s_ff[0]  <= sp_s;
         pw_fx_ff[0] <= sp_fix;
         pw_fv_ff[0] <= sp_fixv;
      end
   end

   // ---------------- 2^f as a product of roots, MSB of f first
   for (genvar k = 0; k < EB; k++) begin : g_pw
      localparam logic [30:0] ROOT = gc_pkg::root_q30(k);
      logic [61:0] prod;
      always_comb prod = 62'(pw_p_ff[k]) * 62'(ROOT);
      always_ff @(posedge clock) begin
         if (adv) begin
            pw_p_ff[k+1]  <= pw_f_ff[k][EB-1-k] ? prod[60:30] : pw_p_ff[k];
            pw_f_ff[k+1]  <= pw_f_ff[k];
            pw_s_ff[k+1]  <= pw_s_ff[k];
            pw_fx_ff[k+1] <= pw_fx_ff[k];
            pw_fv_ff[k+1] <= pw_fv_ff[k];
         end
      end
   end

   // ---------------- round half up, saturate
   logic [31:0]   rd_sum;
   logic [31:0]   rd_val;
   logic [SB-1:0] y_in;
   logic [SB-1:0] y_ff;

   always_comb begin
      rd_sum = {1'b0, pw_p_ff[EB]} + (32'd1 << (pw_s_ff[EB] - SW'(1)));
      rd_val = rd_sum >> pw_s_ff[EB];
      if (pw_fx_ff[EB])               y_in = pw_fv_ff[EB];
      else if (rd_val > 32'(SMAX))    y_in = SMAX;
      else                            y_in = rd_val[SB-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) y_ff <= y_in;
   end

   assign y_out = y_ff;

endmodule

FILE: src/per_channel_gamma_correction_top.sv
// channel  ports       beat contents (low bit first)
// req      req_t*      tdata: red, green, blue, alpha, channel_enable; tlast: row end
// rsp      rsp_t*      tdata: red, green, blue, alpha; tlast: row end
// csr      csr_*       write only, index 0..3 = gamma red, green, blue, alpha (u3.13)
//
// One pixel per cycle while rsp is not stalled; the pipeline holds the log squaring chain,
// the bit-per-stage divider and the root chain.
// Reset is synchronous and clears the valid bits and the gamma registers.
// A stalled rsp holds the whole pipeline; req_tready drops in the same cycle.
module per_channel_gamma_correction_top #(
   parameter int CHANNEL_COUNT = gc_pkg::CHANNEL_COUNT_DEF,
   parameter int SAMPLE_BITS   = gc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // red, green, blue, alpha, channel_enable, zero pad
   input  logic [((4*SAMPLE_BITS+4+7)/8)*8-1:0] req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // red, green, blue, alpha, zero pad
   output logic [((4*SAMPLE_BITS+7)/8)*8-1:0]   rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [gc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gc_pkg::GAMMA_BITS-1:0]       csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int NS    = gc_pkg::NUM_SLOTS;
   localparam int DEPTH = gc_pkg::depth(SB);
   localparam int OW    = ((4*SAMPLE_BITS+7)/8)*8;

   logic [gc_pkg::GAMMA_BITS-1:0] gamma_ff [NS];
   logic                          vld_ff   [DEPTH];
   logic                          last_ff  [DEPTH];
   logic                          adv;
   logic                          all_zero;
   logic [NS-1:0]                 chan_en;
   logic [NS*SB-1:0]              y_bus;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) gamma_ff[i] <= '0;
      end else if (csr_we) begin
         gamma_ff[csr_index] <= csr_wdata;
      end
   end

   assign adv        = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = adv;
   assign chan_en    = req_tdata[NS*SB +: NS];

   always_comb begin
      all_zero = 1'b1;
      for (int i = 0; i < NS; i++) begin
         if (gamma_ff[i] != '0) all_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff[0] <= req_tlast;
         for (int i = 1; i < DEPTH; i++) last_ff[i] <= last_ff[i-1];
      end
   end

   for (genvar c = 0; c < NS; c++) begin : g_ch
      if (c < CHANNEL_COUNT) begin : g_live
         gc_chan #(.SB(SB)) u_chan (
            .clock (clock),
            .adv   (adv),
            .apply (!all_zero && chan_en[c]),
            .gamma (gamma_ff[c]),
            .x_in  (req_tdata[c*SB +: SB]),
            .y_out (y_bus[c*SB +: SB])
         );
      end else begin : g_pass
         logic [SB-1:0] dly_ff [DEPTH];
         always_ff @(posedge clock) begin
            if (adv) begin
               dly_ff[0] <= req_tdata[c*SB +: SB];
               for (int i = 1; i < DEPTH; i++) dly_ff[i] <= dly_ff[i-1];
            end
         end
         assign y_bus[c*SB +: SB] = dly_ff[DEPTH-1];
      end
   end

   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tlast  = last_ff[DEPTH-1];
   assign rsp_tdata  = OW'(y_bus);

endmodule
